FILE: design/hes_pkg.sv
`timescale 1ns / 1ps
// hes_pkg: fixed-point formats and result type shared by the event screen.
// No dependencies; imported by hes_div, hes_sqrt, hes_lane and the top level.
package hes_pkg;

  // Ratio and bound values carry 16 fraction bits.
  localparam int Q_FRAC = 16;
  // Saturated ratio magnitude: 31 bits, cap at all ones.
  localparam int RATIO_W = 31;
  localparam logic [RATIO_W-1:0] RATIO_CAP = '1;
  // Square root of a Q.32 radicand below 2^62.
  localparam int ROOT_W = 31;
  localparam int RAD_W = 2 * ROOT_W;
  // Raw coefficient field width in the shape and scale registers.
  localparam int COEF_RAW_W = 16;
  // Configuration data width.
  localparam int CFG_W = 64;

  typedef struct packed {
    logic valid;
    logic bad;
  } hes_res_t;

endpackage

FILE: design/hes_div.sv
`timescale 1ns / 1ps
// hes_div: pipelined unsigned divider, one quotient bit per stage, saturating at RATIO_CAP.
// Depends on hes_pkg.
module hes_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic [hes_pkg::RATIO_W-1:0]  quo,
  output logic [SIDE_W-1:0]            side_out
);
  import hes_pkg::*;

  localparam int EXT_W = NUM_W + RATIO_W;

  logic [EXT_W-1:0] num_ext;
  logic [NUM_W-1:0] num_hi;
  logic             sat_in;

  logic               vld_s  [0:RATIO_W];
  logic               sat_s  [0:RATIO_W];
  logic [SIDE_W-1:0]  side_s [0:RATIO_W];
  logic [RATIO_W-1:0] wq_s   [0:RATIO_W];
  logic [DEN_W-1:0]   den_s  [0:RATIO_W-1];
  logic [DEN_W-1:0]   rem_s  [0:RATIO_W-1];

  assign num_ext = {{RATIO_W{1'b0}}, num};
  assign num_hi  = num_ext[EXT_W-1:RATIO_W];
  // quotient would need more than RATIO_W bits
  assign sat_in  = {{DEN_W{1'b0}}, num_hi} >= {{NUM_W{1'b0}}, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= in_valid;
    end
    sat_s[0]  <= sat_in;
    side_s[0] <= side_in;
    wq_s[0]   <= num_ext[RATIO_W-1:0];
    den_s[0]  <= den;
    rem_s[0]  <= DEN_W'(num_hi);
  end

  for (genvar gi = 0; gi < RATIO_W; gi++) begin : g_step
    logic [DEN_W:0] trial;
    logic           fit;

    assign trial = {rem_s[gi], wq_s[gi][RATIO_W-1]};
    assign fit   = trial >= {1'b0, den_s[gi]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[gi+1] <= 1'b0;
      end else begin
        vld_s[gi+1] <= vld_s[gi];
      end
      sat_s[gi+1]  <= sat_s[gi];
      side_s[gi+1] <= side_s[gi];
      wq_s[gi+1]   <= {wq_s[gi][RATIO_W-2:0], fit};
    end

    if (gi < RATIO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        den_s[gi+1] <= den_s[gi];
        rem_s[gi+1] <= fit ? DEN_W'(trial - {1'b0, den_s[gi]}) : DEN_W'(trial);
      end
    end
  end

  assign out_valid = vld_s[RATIO_W];
  assign quo       = sat_s[RATIO_W] ? RATIO_CAP : wq_s[RATIO_W];
  assign side_out  = side_s[RATIO_W];

endmodule

FILE: design/hes_sqrt.sv
`timescale 1ns / 1ps
// hes_sqrt: pipelined floor square root, one root bit per stage.
// Depends on hes_pkg.
module hes_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [hes_pkg::RAD_W-1:0]   rad,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [hes_pkg::ROOT_W-1:0]  root,
  output logic [SIDE_W-1:0]           side_out
);
  import hes_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int TRY_W = ROOT_W + 4;

  logic              vld_s  [0:ROOT_W];
  logic [SIDE_W-1:0] side_s [0:ROOT_W];
  logic [ROOT_W-1:0] root_s [0:ROOT_W];
  logic [REM_W-1:0]  rem_s  [0:ROOT_W-1];
  logic [RAD_W-1:0]  rad_s  [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= in_valid;
    end
    side_s[0] <= side_in;
    root_s[0] <= '0;
    rem_s[0]  <= '0;
    rad_s[0]  <= rad;
  end

  for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_step
    logic [TRY_W-1:0] trial;
    logic [TRY_W-1:0] test;
    logic             fit;

    assign trial = {rem_s[gi], rad_s[gi][RAD_W-1 -: 2]};
    assign test  = {2'b00, root_s[gi], 2'b01};
    assign fit   = trial >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[gi+1] <= 1'b0;
      end else begin
        vld_s[gi+1] <= vld_s[gi];
      end
      side_s[gi+1] <= side_s[gi];
      root_s[gi+1] <= {root_s[gi][ROOT_W-2:0], fit};
    end

    if (gi < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_s[gi+1] <= fit ? REM_W'(trial - test) : REM_W'(trial);
        rad_s[gi+1] <= {rad_s[gi][RAD_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld_s[ROOT_W];
  assign root      = root_s[ROOT_W];
  assign side_out  = side_s[ROOT_W];

endmodule

FILE: design/hes_lane.sv
`timescale 1ns / 1ps
// hes_lane: full screen of one axis, ratio dividers, hyperbola dividers, roots, bounds.
// Depends on hes_pkg, hes_div and hes_sqrt.
module hes_lane #(
  parameter int AMP_WIDTH = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [AMP_WIDTH-1:0]         amp_first,
  input  logic signed [AMP_WIDTH-1:0]         amp_middle,
  input  logic signed [AMP_WIDTH-1:0]         amp_last,
  input  logic [hes_pkg::CFG_W-1:0]           shape_word,
  input  logic [hes_pkg::COEF_RAW_W-1:0]      scale_b,
  output hes_pkg::hes_res_t                   res
);
  import hes_pkg::*;

  localparam int SUM_W  = AMP_WIDTH + 2;
  localparam int MAG_W  = AMP_WIDTH;
  localparam int DEN_W  = AMP_WIDTH + 1;
  localparam int NUM_W  = MAG_W + Q_FRAC;
  localparam int CSH    = Q_FRAC - COEF_FRAC_BITS;
  localparam int COEF_W = COEF_RAW_W + CSH;
  localparam int FB_W   = RATIO_W + 1;
  localparam int CMP_W  = FB_W + 2;
  localparam int DQ_W   = CMP_W - 1;
  localparam int NUMQ_W = DQ_W + Q_FRAC;
  localparam int PROD_W = COEF_W + ROOT_W + 1;
  localparam int V_W    = PROD_W - Q_FRAC;
  localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * Q_FRAC);
  localparam logic signed [PROD_W-1:0] RND = PROD_W'((1 << Q_FRAC) - 1);

  typedef struct packed {
    logic s_zero;
    logic bad_lin;
    logic a_zero;
    logic knee;
  } flags_t;

  localparam int FL_W = $bits(flags_t);

  // ---- stage 1: sum, magnitudes
  logic signed [SUM_W-1:0] a1x, a2x, a3x, sum, diff;
  logic [MAG_W-1:0] a2_mag, diff_mag;
  logic [DEN_W-1:0] sum_mag;

  assign a1x      = SUM_W'(amp_first);
  assign a2x      = SUM_W'(amp_middle);
  assign a3x      = SUM_W'(amp_last);
  assign sum      = a1x + a2x + a3x;
  assign diff     = a3x - a1x;
  assign a2_mag   = MAG_W'(a2x[SUM_W-1] ? -a2x : a2x);
  assign diff_mag = MAG_W'(diff[SUM_W-1] ? -diff : diff);
  assign sum_mag  = DEN_W'(sum[SUM_W-1] ? -sum : sum);

  logic             s1_valid, s1_zero, s1_fbneg;
  logic [NUM_W-1:0] s1_num_fb, s1_num_fp;
  logic [DEN_W-1:0] s1_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_zero   <= (sum == '0);
    s1_fbneg  <= amp_middle[AMP_WIDTH-1] ^ sum[SUM_W-1];
    s1_num_fb <= {a2_mag, {Q_FRAC{1'b0}}};
    s1_num_fp <= {diff_mag, {Q_FRAC{1'b0}}};
    s1_den    <= sum_mag;
  end

  logic               v_fb, v_fp, d_fbneg, d_zero;
  logic [RATIO_W-1:0] q_fb, q_fp;

  hes_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_fb (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .num(s1_num_fb), .den(s1_den),
    .side_in(s1_fbneg), .out_valid(v_fb), .quo(q_fb), .side_out(d_fbneg)
  );

  hes_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_fp (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .num(s1_num_fp), .den(s1_den),
    .side_in(s1_zero), .out_valid(v_fp), .quo(q_fp), .side_out(d_zero)
  );

  // ---- stage 2: signed fb
  logic signed [FB_W-1:0] fb_abs;
  logic                   s2_valid, s2_zero;
  logic signed [FB_W-1:0] s2_fb;
  logic [RATIO_W-1:0]     s2_fp;

  assign fb_abs = $signed(FB_W'(q_fb));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= v_fb & v_fp;
    end
    s2_zero <= d_zero;
    s2_fb   <= d_fbneg ? -fb_abs : fb_abs;
    s2_fp   <= q_fp;
  end

  // ---- stage 3: linear limits and hyperbola numerators
  logic signed [COEF_W-1:0] h_c, hd_c, a_c, c_c, b_c;
  logic signed [CMP_W-1:0]  fbx, hp, hm, ax, cx, lim_hi, knee_lim, dp, dm;
  logic [DQ_W-1:0]          dp_mag, dm_mag;
  logic [COEF_W-1:0]        a_mag;
  flags_t                   fl_now;

  assign h_c  = {shape_word[63:48], {CSH{1'b0}}};
  assign hd_c = {shape_word[47:32], {CSH{1'b0}}};
  assign a_c  = {shape_word[31:16], {CSH{1'b0}}};
  assign c_c  = {shape_word[15:0], {CSH{1'b0}}};
  assign b_c  = {scale_b, {CSH{1'b0}}};

  assign fbx      = CMP_W'(s2_fb);
  assign hp       = CMP_W'(h_c) + CMP_W'(hd_c);
  assign hm       = CMP_W'(h_c) - CMP_W'(hd_c);
  assign ax       = CMP_W'(a_c);
  assign cx       = CMP_W'(c_c);
  assign lim_hi   = hp - ax;
  assign knee_lim = hm - ax;
  assign dp       = fbx - hp;
  assign dm       = fbx - hm;
  assign dp_mag   = DQ_W'(dp[CMP_W-1] ? -dp : dp);
  assign dm_mag   = DQ_W'(dm[CMP_W-1] ? -dm : dm);
  assign a_mag    = COEF_W'(ax[CMP_W-1] ? -ax : ax);

  always_comb begin
    fl_now.s_zero  = s2_zero;
    fl_now.bad_lin = (fbx < cx) || s2_fb[FB_W-1] || (fbx > lim_hi);
    fl_now.a_zero  = (a_c == '0);
    fl_now.knee    = (fbx <= knee_lim);
  end

  logic               s3_valid;
  flags_t             s3_flags;
  logic [RATIO_W-1:0] s3_fp;
  logic [NUMQ_W-1:0]  s3_num_p, s3_num_m;
  logic [COEF_W-1:0]  s3_den_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_flags <= fl_now;
    s3_fp    <= s2_fp;
    s3_num_p <= {dp_mag, {Q_FRAC{1'b0}}};
    s3_num_m <= {dm_mag, {Q_FRAC{1'b0}}};
    s3_den_a <= a_mag;
  end

  logic               v_qp, v_qm;
  logic [RATIO_W-1:0] q_p, q_m, d_fp;
  logic [FL_W-1:0]    d_flags;

  hes_div #(.NUM_W(NUMQ_W), .DEN_W(COEF_W), .SIDE_W(FL_W)) u_div_p (
    .clk(clk), .rst(rst), .in_valid(s3_valid), .num(s3_num_p), .den(s3_den_a),
    .side_in(s3_flags), .out_valid(v_qp), .quo(q_p), .side_out(d_flags)
  );

  hes_div #(.NUM_W(NUMQ_W), .DEN_W(COEF_W), .SIDE_W(RATIO_W)) u_div_m (
    .clk(clk), .rst(rst), .in_valid(s3_valid), .num(s3_num_m), .den(s3_den_a),
    .side_in(s3_fp), .out_valid(v_qm), .quo(q_m), .side_out(d_fp)
  );

  // ---- stage 4: squares
  logic               s4_valid;
  flags_t             s4_flags;
  logic [RATIO_W-1:0] s4_fp;
  logic [RAD_W-1:0]   s4_sq_p, s4_sq_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= v_qp & v_qm;
    end
    s4_flags <= d_flags;
    s4_fp    <= d_fp;
    s4_sq_p  <= RAD_W'(q_p) * q_p;
    s4_sq_m  <= RAD_W'(q_m) * q_m;
  end

  // ---- stage 5: radicands q^2 - 1
  logic               s5_valid, s5_ok_p, s5_ok_m;
  flags_t             s5_flags;
  logic [RATIO_W-1:0] s5_fp;
  logic [RAD_W-1:0]   s5_rad_p, s5_rad_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_flags <= s4_flags;
    s5_fp    <= s4_fp;
    s5_ok_p  <= (s4_sq_p >= ONE_SQ);
    s5_ok_m  <= (s4_sq_m >= ONE_SQ);
    s5_rad_p <= s4_sq_p - ONE_SQ;
    s5_rad_m <= s4_sq_m - ONE_SQ;
  end

  logic              v_rp, v_rm;
  logic [ROOT_W-1:0] root_p, root_m;
  logic [FL_W+1:0]   r_side;
  logic [RATIO_W-1:0] r_fp;

  hes_sqrt #(.SIDE_W(FL_W + 2)) u_sqrt_p (
    .clk(clk), .rst(rst), .in_valid(s5_valid), .rad(s5_rad_p),
    .side_in({s5_flags, s5_ok_p, s5_ok_m}), .out_valid(v_rp), .root(root_p),
    .side_out(r_side)
  );

  hes_sqrt #(.SIDE_W(RATIO_W)) u_sqrt_m (
    .clk(clk), .rst(rst), .in_valid(s5_valid), .rad(s5_rad_m),
    .side_in(s5_fp), .out_valid(v_rm), .root(root_m), .side_out(r_fp)
  );

  // ---- stage 6: scale by B
  logic                     s6_valid, s6_ok_p, s6_ok_m;
  flags_t                   s6_flags;
  logic [RATIO_W-1:0]       s6_fp;
  logic signed [PROD_W-1:0] s6_prod_p, s6_prod_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= v_rp & v_rm;
    end
    s6_flags  <= r_side[FL_W+1:2];
    s6_ok_p   <= r_side[1];
    s6_ok_m   <= r_side[0];
    s6_fp     <= r_fp;
    s6_prod_p <= PROD_W'(b_c) * PROD_W'($signed({1'b0, root_p}));
    s6_prod_m <= PROD_W'(b_c) * PROD_W'($signed({1'b0, root_m}));
  end

  // ---- stage 7: bounds, compares, verdict
  logic signed [PROD_W-1:0] adj_p, adj_m, sh_p, sh_m;
  logic signed [V_W-1:0]    vb_p, vb_m, fpx;
  logic                     gt_m, lt_p, bad_now;

  // divide by 2^16 toward zero
  assign adj_p = s6_prod_p[PROD_W-1] ? s6_prod_p + RND : s6_prod_p;
  assign adj_m = s6_prod_m[PROD_W-1] ? s6_prod_m + RND : s6_prod_m;
  assign sh_p  = adj_p >>> Q_FRAC;
  assign sh_m  = adj_m >>> Q_FRAC;
  assign vb_p  = V_W'(sh_p);
  assign vb_m  = V_W'(sh_m);
  assign fpx   = $signed(V_W'(s6_fp));
  assign gt_m  = fpx > vb_m;
  assign lt_p  = fpx < vb_p;

  always_comb begin
    if (s6_flags.s_zero) begin
      bad_now = 1'b0;
    end else if (s6_flags.bad_lin) begin
      bad_now = 1'b1;
    end else if (s6_flags.a_zero) begin
      bad_now = 1'b0;
    end else if (s6_flags.knee) begin
      // below the knee the event must sit strictly inside both branches
      bad_now = !(s6_ok_m && gt_m && s6_ok_p && lt_p);
    end else begin
      bad_now = s6_ok_p && !lt_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= s6_valid;
    end
    res.bad <= bad_now;
  end

endmodule

FILE: design/hyperbolic_event_screen_top.sv
`timescale 1ns / 1ps
// hyperbolic_event_screen_top: two-axis event screen, config registers, lane merge.
// Depends on hes_pkg and hes_lane (which uses hes_div and hes_sqrt).
//
// Usage:
//   Input channel: drive the six amplitudes and raise start; the item is
//   taken at a rising edge where start is high and busy is low. busy is only
//   high while rst is asserted, so one item per clock is taken otherwise.
//   Result channel: done pulses for one cycle with u_bad and v_bad. There is
//   no backpressure; the receiver must take every result as it appears.
//   Path: from the taking edge to the edge that takes the result, the item
//   passes the two ratio dividers in series (fb, then the hyperbola quotient),
//   each an input register and 31 quotient-bit stages, the square root (an
//   input register and 31 root-bit stages), and eight single-register stages
//   around them.
//   Throughput: one item per cycle, results in input order.
//   Config: cfg_we/cfg_index/cfg_data write one register per edge, no wait.
//   Write only when no items are in flight; the lanes read the registers live.
//   Reset: synchronous rst clears all coefficients to zero and empties the
//   pipeline; items in flight are dropped.
//   Structure: one lane per axis (U, V) side by side, merged into one result.
module hyperbolic_event_screen_top #(
  parameter int AMP_WIDTH = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [hes_pkg::CFG_W-1:0]    cfg_data,
  input  logic signed [AMP_WIDTH-1:0]  u_amp_first,
  input  logic signed [AMP_WIDTH-1:0]  u_amp_middle,
  input  logic signed [AMP_WIDTH-1:0]  u_amp_last,
  input  logic signed [AMP_WIDTH-1:0]  v_amp_first,
  input  logic signed [AMP_WIDTH-1:0]  v_amp_middle,
  input  logic signed [AMP_WIDTH-1:0]  v_amp_last,
  output logic                         done,
  output logic                         u_bad,
  output logic                         v_bad
);
  import hes_pkg::*;

  // register indexes
  localparam logic [1:0] CFG_U_SHAPE = 2'd0;
  localparam logic [1:0] CFG_U_SCALE = 2'd1;
  localparam logic [1:0] CFG_V_SHAPE = 2'd2;
  localparam logic [1:0] CFG_V_SCALE = 2'd3;

  // accept edge to result edge
  localparam int LATENCY = 2 * (RATIO_W + 1) + (ROOT_W + 1) + 8;

  logic [CFG_W-1:0]      u_shape, v_shape;
  logic [COEF_RAW_W-1:0] u_scale, v_scale;
  logic                  take;
  hes_res_t              u_res, v_res;

  assign busy = rst;
  assign take = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_shape <= '0;
      u_scale <= '0;
      v_shape <= '0;
      v_scale <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_U_SHAPE: u_shape <= cfg_data;
        CFG_U_SCALE: u_scale <= cfg_data[COEF_RAW_W-1:0];
        CFG_V_SHAPE: v_shape <= cfg_data;
        CFG_V_SCALE: v_scale <= cfg_data[COEF_RAW_W-1:0];
        default: ;
      endcase
    end
  end

  hes_lane #(.AMP_WIDTH(AMP_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_u (
    .clk(clk), .rst(rst), .in_valid(take),
    .amp_first(u_amp_first), .amp_middle(u_amp_middle), .amp_last(u_amp_last),
    .shape_word(u_shape), .scale_b(u_scale), .res(u_res)
  );

  hes_lane #(.AMP_WIDTH(AMP_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_v (
    .clk(clk), .rst(rst), .in_valid(take),
    .amp_first(v_amp_first), .amp_middle(v_amp_middle), .amp_last(v_amp_last),
    .shape_word(v_shape), .scale_b(v_scale), .res(v_res)
  );

  // merge: both lanes run in lockstep, so their verdicts arrive together
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= u_res.valid & v_res.valid;
    end
    u_bad <= u_res.bad;
    v_bad <= v_res.bad;
  end

  // lanes must stay aligned
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    u_res.valid == v_res.valid)
    else $error("axis lanes out of step");

  // every result traces back to a matching taken item, at the LATENCY offset
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LATENCY))
    else $error("result without a matching item");

  // a lane verdict is always followed by the merged strobe
  a_merge_strobe: assert property (@(posedge clk) disable iff (rst)
    (u_res.valid && v_res.valid) |=> done)
    else $error("merged result strobe missing");

endmodule
